// ===== sv/smd_pkg.sv =====
`timescale 1ns / 1ps

package smd_pkg;

  // Window and sample geometry.
  localparam int WINDOW_LOG2 = 3;
  localparam int AXIS_COUNT  = 3;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_LEN     = 1 << WINDOW_LOG2;

  // Field widths of the channels.
  localparam int ACCEL_W  = 16;
  localparam int TIME_W   = 32;
  localparam int ENERGY_W = 18;
  localparam int DCOUNT_W = 8;
  localparam int FIELD_COUNT = 3;

  // Internal arithmetic widths.
  localparam int WIDE_W  = (SAMPLE_BITS > ACCEL_W) ? SAMPLE_BITS : ACCEL_W;
  localparam int SUM_W   = SAMPLE_BITS + WINDOW_LOG2;
  localparam int DIFF_W  = SUM_W + 1;
  localparam int DEV_W   = SAMPLE_BITS + 1;
  localparam int TOT_W   = ((DEV_W + 2 > ENERGY_W) ? DEV_W + 2 : ENERGY_W) + 1;
  localparam int ESUM_W  = ENERGY_W + WINDOW_LOG2;
  localparam int FILL_W  = WINDOW_LOG2 + 1;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [DCOUNT_W-1:0] RUN_MAX    = '1;

  // Configuration register map.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DCOUNT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 2'd3;

  localparam logic [ENERGY_W-1:0] THRESHOLD_RST = 18'd2048;
  localparam logic [ENERGY_W-1:0] FLOOR_RST     = 18'd91;
  localparam logic [DCOUNT_W-1:0] DCOUNT_RST    = 8'd32;
  localparam logic [TIME_W-1:0]   DELAY_RST     = 32'd0;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef smp_t [AXIS_COUNT-1:0] axis_vec_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_threshold;
    logic [ENERGY_W-1:0] min_energy;
    logic [DCOUNT_W-1:0] decision_count;
    logic [TIME_W-1:0]   event_delay;
  } cfg_t;

  typedef struct packed {
    logic axis_shift;
    logic energy_shift;
  } cell_ctl_t;

  // Take the low SAMPLE_BITS bits of an input field as a two's complement value.
  function automatic smp_t sext_sample(input logic [ACCEL_W-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v);
    return smp_t'(wide[SAMPLE_BITS-1:0]);
  endfunction

endpackage

// ===== sv/smd_if.sv =====
`timescale 1ns / 1ps

// Sample channel: one timestamped three-axis sample per transaction.
interface smd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [smd_pkg::ACCEL_W-1:0]  accel_x;
  logic signed [smd_pkg::ACCEL_W-1:0]  accel_y;
  logic signed [smd_pkg::ACCEL_W-1:0]  accel_z;
  logic        [smd_pkg::TIME_W-1:0]   sample_time;

  modport source (output valid, accel_x, accel_y, accel_z, sample_time, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, sample_time, output ready);
endinterface

// Result channel: one decision per sample.
interface smd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                motion_now;
  logic                                motion_event;
  logic        [smd_pkg::TIME_W-1:0]   event_time;
  logic        [smd_pkg::ENERGY_W-1:0] energy_level;
  logic                                windows_full;

  modport source (output valid, motion_now, motion_event, event_time, energy_level,
                  windows_full, input ready);
  modport sink   (input valid, motion_now, motion_event, event_time, energy_level,
                  windows_full, output ready);
endinterface

// ===== sv/smd_cell.sv =====
`timescale 1ns / 1ps

// One slot of the moving windows: a sample of every axis and one energy value.
// The axis part and the energy part shift toward the older neighbor separately.
module smd_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smd_pkg::cell_ctl_t                ctl,
  input  smd_pkg::axis_vec_t                axis_in,
  input  logic [smd_pkg::ENERGY_W-1:0]      energy_in,
  output smd_pkg::axis_vec_t                axis_out,
  output logic [smd_pkg::ENERGY_W-1:0]      energy_out
);

  smd_pkg::axis_vec_t               axis_r;
  logic [smd_pkg::ENERGY_W-1:0]     energy_r;

  // Axis samples move one slot on each accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
    end else if (ctl.axis_shift) begin
      axis_r <= axis_in;
    end
  end

  // Energy values move one slot when a deviation total enters the energy stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
    end else if (ctl.energy_shift) begin
      energy_r <= energy_in;
    end
  end

  assign axis_out   = axis_r;
  assign energy_out = energy_r;

endmodule

// ===== sv/smd_cfg.sv =====
`timescale 1ns / 1ps

// APB register file holding the four configuration registers.
module smd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [smd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [smd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [smd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output smd_pkg::cfg_t                     cfg
);

  smd_pkg::cfg_t                      cfg_r;
  smd_pkg::cfg_t                      cfg_nxt;
  logic [smd_pkg::CFG_IDX_W-1:0]      reg_idx;
  logic                               wr_en;

  assign reg_idx    = cfg_paddr[smd_pkg::CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Write decode; each register keeps only its own width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        smd_pkg::REG_THRESHOLD:
          cfg_nxt.energy_threshold = cfg_pwdata[smd_pkg::ENERGY_W-1:0];
        smd_pkg::REG_FLOOR:     cfg_nxt.min_energy     = cfg_pwdata[smd_pkg::ENERGY_W-1:0];
        smd_pkg::REG_DCOUNT:    cfg_nxt.decision_count = cfg_pwdata[smd_pkg::DCOUNT_W-1:0];
        smd_pkg::REG_DELAY:     cfg_nxt.event_delay    = cfg_pwdata[smd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_threshold <= smd_pkg::THRESHOLD_RST;
      cfg_r.min_energy       <= smd_pkg::FLOOR_RST;
      cfg_r.decision_count   <= smd_pkg::DCOUNT_RST;
      cfg_r.event_delay      <= smd_pkg::DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      smd_pkg::REG_THRESHOLD: cfg_prdata = smd_pkg::CFG_DATA_W'(cfg_r.energy_threshold);
      smd_pkg::REG_FLOOR:     cfg_prdata = smd_pkg::CFG_DATA_W'(cfg_r.min_energy);
      smd_pkg::REG_DCOUNT:    cfg_prdata = smd_pkg::CFG_DATA_W'(cfg_r.decision_count);
      smd_pkg::REG_DELAY:     cfg_prdata = smd_pkg::CFG_DATA_W'(cfg_r.event_delay);
      default:                cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/significant_motion_detector.sv =====
`timescale 1ns / 1ps

// Significant motion detector.
// in_ch carries one timestamped accelerometer sample per transaction; out_ch
// returns exactly one result per sample, in order. The APB port (cfg_*) holds
// the energy threshold, the minimum energy, the decision count and the event
// delay at byte addresses 0, 4, 8 and 12; write it only while no sample is in
// flight.
// The moving windows are a row of eight cells that shift on every sample, so
// the oldest sample drops out of the last cell while the new one enters.
// A sample passes four register stages in order: axis sums, deviation total,
// energy window, decision; the result is held in the output register until
// taken. One sample per cycle is sustained while the receiver keeps taking
// results.
// Each stage has its own valid flag and moves on whenever the stage after it
// is free or empties in the same cycle, so the block keeps taking samples
// while a result waits in the output register. When the receiver stalls, the
// stages fill up and in_ch.ready falls once all four hold a sample.
// A synchronous reset (rst_n low) empties the pipeline, clears all windows,
// sums, the fill count and the run counter, and restores register defaults.
module significant_motion_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  smd_in_if.sink                            in_ch,
  smd_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [smd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [smd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [smd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int NA = smd_pkg::AXIS_COUNT;
  localparam int NW = smd_pkg::WIN_LEN;
  localparam int WL = smd_pkg::WINDOW_LOG2;

  smd_pkg::cfg_t cfg;

  smd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Pipeline flow control.
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic accept, take2, take3, take4;

  assign take4        = s3_v_r && (!out_v_r || out_ch.ready);
  assign take3        = s2_v_r && (!s3_v_r || take4);
  assign take2        = s1_v_r && (!s2_v_r || take3);
  assign in_ch.ready  = !s1_v_r || take2;
  assign accept       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) s1_v_r <= 1'b1;
      else if (take2) s1_v_r <= 1'b0;
      if (take2) s2_v_r <= 1'b1;
      else if (take3) s2_v_r <= 1'b0;
      if (take3) s3_v_r <= 1'b1;
      else if (take4) s3_v_r <= 1'b0;
      if (take4) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  // Row of window cells.
  smd_pkg::cell_ctl_t                 cell_ctl;
  smd_pkg::axis_vec_t                 new_axis;
  logic [smd_pkg::ENERGY_W-1:0]       new_energy;
  smd_pkg::axis_vec_t                 cell_axis   [NW];
  logic [smd_pkg::ENERGY_W-1:0]       cell_energy [NW];

  assign cell_ctl.axis_shift   = accept;
  assign cell_ctl.energy_shift = take3;

  genvar k;
  generate
    for (k = 0; k < NW; k++) begin : g_cell
      if (k == 0) begin : g_head
        smd_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl        (cell_ctl),
          .axis_in    (new_axis),
          .energy_in  (new_energy),
          .axis_out   (cell_axis[k]),
          .energy_out (cell_energy[k])
        );
      end else begin : g_body
        smd_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl        (cell_ctl),
          .axis_in    (cell_axis[k-1]),
          .energy_in  (cell_energy[k-1]),
          .axis_out   (cell_axis[k]),
          .energy_out (cell_energy[k])
        );
      end
    end
  endgenerate

  // Stage 1: running axis sums; the oldest sample leaves from the last cell.
  logic [smd_pkg::ACCEL_W-1:0]               accel_raw [smd_pkg::FIELD_COUNT];
  logic signed [smd_pkg::SUM_W-1:0]          axis_sum_r [NA];
  logic signed [smd_pkg::SUM_W-1:0]          s1_sum_r   [NA];
  smd_pkg::axis_vec_t                        s1_x_r;
  logic [smd_pkg::TIME_W-1:0]                s1_time_r;

  assign accel_raw[0] = in_ch.accel_x;
  assign accel_raw[1] = in_ch.accel_y;
  assign accel_raw[2] = in_ch.accel_z;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      new_axis[a] = smd_pkg::sext_sample(accel_raw[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) axis_sum_r[a] <= '0;
    end else if (accept) begin
      for (int a = 0; a < NA; a++) begin
        axis_sum_r[a] <= axis_sum_r[a] - smd_pkg::SUM_W'(cell_axis[NW-1][a])
                         + smd_pkg::SUM_W'(new_axis[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < NA; a++) begin
        s1_sum_r[a] <= axis_sum_r[a] - smd_pkg::SUM_W'(cell_axis[NW-1][a])
                       + smd_pkg::SUM_W'(new_axis[a]);
      end
      s1_x_r    <= new_axis;
      s1_time_r <= in_ch.sample_time;
    end
  end

  // Stage 2: absolute deviation from the floored mean, summed and saturated.
  logic signed [smd_pkg::SUM_W-1:0]   mean_c;
  logic signed [smd_pkg::DIFF_W-1:0]  diff_c;
  logic [smd_pkg::DIFF_W-1:0]         mag_c;
  logic [smd_pkg::TOT_W-1:0]          total_c;
  logic [smd_pkg::ENERGY_W-1:0]       s2_dev_r;
  logic [smd_pkg::TIME_W-1:0]         s2_time_r;

  always_comb begin
    total_c = '0;
    mean_c  = '0;
    diff_c  = '0;
    mag_c   = '0;
    for (int a = 0; a < NA; a++) begin
      mean_c  = s1_sum_r[a] >>> WL;
      diff_c  = smd_pkg::DIFF_W'(s1_x_r[a]) - smd_pkg::DIFF_W'(mean_c);
      mag_c   = diff_c[smd_pkg::DIFF_W-1] ? -diff_c : diff_c;
      total_c = total_c + smd_pkg::TOT_W'(mag_c[smd_pkg::DEV_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      s2_dev_r  <= (total_c > smd_pkg::TOT_W'(smd_pkg::ENERGY_MAX)) ?
                   smd_pkg::ENERGY_MAX : total_c[smd_pkg::ENERGY_W-1:0];
      s2_time_r <= s1_time_r;
    end
  end

  // Stage 3: energy window, smoothed energy with floor, fill count.
  logic [smd_pkg::ESUM_W-1:0]         esum_r;
  logic [smd_pkg::ESUM_W-1:0]         esum_nxt;
  logic [smd_pkg::ENERGY_W-1:0]       energy_c;
  logic [smd_pkg::FILL_W-1:0]         fill_r;
  logic [smd_pkg::FILL_W-1:0]         fill_nxt;
  logic [smd_pkg::ENERGY_W-1:0]       s3_energy_r;
  logic                               s3_full_r;
  logic [smd_pkg::TIME_W-1:0]         s3_time_r;

  assign new_energy = s2_dev_r;
  assign esum_nxt   = esum_r - smd_pkg::ESUM_W'(cell_energy[NW-1])
                      + smd_pkg::ESUM_W'(s2_dev_r);
  assign energy_c   = smd_pkg::ENERGY_W'(esum_nxt >> WL);
  assign fill_nxt   = (fill_r == smd_pkg::FILL_W'(NW)) ? fill_r
                      : fill_r + smd_pkg::FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r <= '0;
      fill_r <= '0;
    end else if (take3) begin
      esum_r <= esum_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take3) begin
      s3_energy_r <= (energy_c < cfg.min_energy) ? cfg.min_energy : energy_c;
      s3_full_r   <= (fill_nxt == smd_pkg::FILL_W'(NW));
      s3_time_r   <= s2_time_r;
    end
  end

  // Stage 4: run counter and motion decision into the output register.
  logic [smd_pkg::DCOUNT_W-1:0]       run_r;
  logic [smd_pkg::DCOUNT_W-1:0]       run_inc;
  logic                               was_moving_r;
  logic                               moving_c;
  logic                               out_now_r;
  logic                               out_event_r;
  logic [smd_pkg::TIME_W-1:0]         out_time_r;
  logic [smd_pkg::ENERGY_W-1:0]       out_energy_r;
  logic                               out_full_r;

  always_comb begin
    if (s3_energy_r >= cfg.energy_threshold) begin
      run_inc = (run_r == smd_pkg::RUN_MAX) ? run_r : run_r + smd_pkg::DCOUNT_W'(1);
    end else begin
      run_inc = '0;
    end
    moving_c = s3_full_r && (run_inc > cfg.decision_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= '0;
      was_moving_r <= 1'b0;
    end else if (take4 && s3_full_r) begin
      run_r        <= moving_c ? cfg.decision_count : run_inc;
      was_moving_r <= moving_c;
    end
  end

  always_ff @(posedge clk) begin
    if (take4) begin
      out_now_r    <= moving_c;
      out_event_r  <= moving_c && !was_moving_r;
      out_time_r   <= s3_time_r - cfg.event_delay;
      out_energy_r <= s3_energy_r;
      out_full_r   <= s3_full_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.motion_now   = out_now_r;
  assign out_ch.motion_event = out_event_r;
  assign out_ch.event_time   = out_time_r;
  assign out_ch.energy_level = out_energy_r;
  assign out_ch.windows_full = out_full_r;

  // An event is always a sample with motion declared.
  a_event_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_event_r |-> out_now_r)
    else $error("motion event without motion declared");

  // Motion is only declared once the windows are full.
  a_now_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_now_r |-> out_full_r)
    else $error("motion declared before windows filled");

  // The held decision state agrees with the pending event.
  a_event_was: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_event_r |-> was_moving_r)
    else $error("motion event not recorded in decision state");

  // The fill count never passes the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= smd_pkg::FILL_W'(NW))
    else $error("fill count beyond window length");

  // A sample accepted reaches the first stage on the next edge.
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted sample lost before first stage");

endmodule
